// ===== design/assert_macros.svh =====
// Assertion helpers included by atou64_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is held low.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("port check failed");

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  `ASSERT_CLK(lbl, clk, rst_n, (ante) |-> (cons))

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  `ASSERT_CLK(lbl, clk, rst_n, (ante) |=> (cons))

`endif

// ===== design/atou64_pkg.sv =====
package atou64_pkg;

  // Field widths
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned RADIX_W     = 6;
  localparam int unsigned VALUE_W     = 64;
  localparam int unsigned OFFSET_W    = 16;
  localparam int unsigned OUT_TDATA_W = VALUE_W + OFFSET_W;
  localparam int unsigned OUT_TUSER_W = 2;

  localparam longint unsigned POSITION_LIMIT_DEF = 65535;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;

  // Bases; DIGIT_NONE is never below any 6-bit base
  localparam logic [RADIX_W-1:0] BASE_AUTO  = 6'd0;
  localparam logic [RADIX_W-1:0] BASE_OCT   = 6'd8;
  localparam logic [RADIX_W-1:0] BASE_DEC   = 6'd10;
  localparam logic [RADIX_W-1:0] BASE_HEX   = 6'd16;
  localparam logic [RADIX_W-1:0] DIGIT_NONE = '1;
  localparam logic [RADIX_W-1:0] LETTER_OFS = 6'd10;

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_LEAD   = 6'b000010,
    PH_SIGNED = 6'b000100,
    PH_ZERO   = 6'b001000,
    PH_DIGITS = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_t;

  typedef enum logic [1:0] {
    DS_NONE     = 2'd0,
    DS_DIGITS   = 2'd1,
    DS_OVERFLOW = 2'd2
  } dstat_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [OFFSET_W-1:0] end_offset;
    logic                converted;
    logic                range_error;
  } result_t;

  // Value of a digit or letter, DIGIT_NONE for anything else
  function automatic logic [RADIX_W-1:0] digit_value(input logic [CHAR_W-1:0] ch);
    logic [RADIX_W-1:0] d;
    d = DIGIT_NONE;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      d = RADIX_W'(ch - CH_ZERO);
    end else if (ch >= CH_UA && ch <= CH_UZ) begin
      d = RADIX_W'(ch - CH_UA) + LETTER_OFS;
    end else if (ch >= CH_LA && ch <= CH_LZ) begin
      d = RADIX_W'(ch - CH_LA) + LETTER_OFS;
    end
    return d;
  endfunction

endpackage

// ===== design/ascii_to_unsigned64_parser.sv =====
// ASCII to unsigned 64-bit parser, strtoull style, one character per word.
// Input channel: in_tdata carries the character byte, in_tuser[0] flags the
//   first character of a new string and restarts the parse.
// Config channel: cfg_data is the radix (0 = detect from prefix); the user must write it
//   only while idle (unenforced). cfg_ready is always high. The radix is sampled at start.
// Result channel: at most one word per string, on the first character that is not
//   taken (NUL always ends). tdata = value, end offset; tuser = converted,
//   range error. Characters after the result are dropped until next start.
// Capture: the result goes into the output register, or the skid register if that is full,
//   when the ending character is accepted. Throughput: one character per cycle while
//   in_tready is high, set by the single per-character 64x6 multiply-add on the accumulator.
// Stall: an output register plus a skid register hold up to two results;
//   in_tready drops only while both are full.
// Reset: radix 0, parser idle, characters ignored until a start word,
//   output channel empty.
module ascii_to_unsigned64_parser #(
  parameter longint unsigned POSITION_LIMIT = atou64_pkg::POSITION_LIMIT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [atou64_pkg::CHAR_W-1:0]       in_tdata,   // [7:0] char_code
  input  logic [0:0]                          in_tuser,   // [0] start_of_string
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [atou64_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [63:0] value, [79:64] end_offset
  output logic [atou64_pkg::OUT_TUSER_W-1:0]  out_tuser,  // [0] converted, [1] range_error
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [atou64_pkg::RADIX_W-1:0]      cfg_data
);
  import atou64_pkg::*;

  localparam int POS_W = $clog2(POSITION_LIMIT + 1);
  localparam int EXT_W = (POS_W > OFFSET_W) ? POS_W : OFFSET_W;
  localparam int PROD_W = VALUE_W + RADIX_W;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(POSITION_LIMIT);
  localparam logic [EXT_W-1:0] OFS_MAX = EXT_W'({OFFSET_W{1'b1}});

  // Parser state
  logic [RADIX_W-1:0] radix_r;
  phase_t             phase_r, phase_cur, phase_nxt;
  logic [VALUE_W-1:0] acc_r, acc_cur, acc_nxt;
  logic               neg_r, neg_cur, neg_nxt;
  dstat_t             st_r, st_cur, st_nxt;
  logic [RADIX_W-1:0] base_r, base_cur, base_nxt;
  logic [POS_W-1:0]   pos_r, pos_cur, pos_nxt;

  // Digit step operands and results
  logic [CHAR_W-1:0]  ch;
  logic               is_ws;
  logic               zero_lead;
  logic [RADIX_W-1:0] base_in;
  logic [VALUE_W-1:0] acc_in;
  dstat_t             st_in;
  logic [RADIX_W-1:0] dval;
  logic               dig_ok;
  logic [PROD_W-1:0]  prod;
  logic [VALUE_W-1:0] acc_t;
  dstat_t             st_t;

  logic               in_fire;
  logic               emit;
  logic [EXT_W-1:0]   pos_ext;
  result_t            res;

  // Output buffering
  result_t            out_r, skid_r;
  logic               out_valid_r, skid_valid_r;
  logic               out_pop;

  assign cfg_ready = 1'b1;
  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_pop   = out_valid_r && out_tready;
  assign ch        = in_tdata;

  // Radix register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= BASE_AUTO;
    end else if (cfg_valid && cfg_ready) begin
      radix_r <= cfg_data;
    end
  end

  // State as seen by this character, after a possible restart
  always_comb begin
    phase_cur = phase_r;
    acc_cur   = acc_r;
    neg_cur   = neg_r;
    st_cur    = st_r;
    base_cur  = base_r;
    pos_cur   = pos_r;
    if (in_tuser[0]) begin
      phase_cur = PH_LEAD;
      acc_cur   = '0;
      neg_cur   = 1'b0;
      st_cur    = DS_NONE;
      base_cur  = radix_r;
      pos_cur   = '0;
    end
  end

  // Digit step: resolve base, multiply-add, overflow check
  always_comb begin
    is_ws     = (ch >= CH_TAB && ch <= CH_CR) || ch == CH_SPACE;
    zero_lead = (base_cur == BASE_AUTO || base_cur == BASE_HEX) && ch == CH_ZERO;

    case (phase_cur)
      PH_ZERO:             base_in = (base_cur == BASE_AUTO) ? BASE_OCT : base_cur;
      PH_LEAD, PH_SIGNED:  base_in = (base_cur == BASE_AUTO) ? BASE_DEC : base_cur;
      default:             base_in = base_cur;
    endcase

    // after a lone leading zero, that zero counts as one converted digit
    acc_in = (phase_cur == PH_ZERO) ? '0 : acc_cur;
    st_in  = (phase_cur == PH_ZERO) ? DS_DIGITS : st_cur;

    dval   = digit_value(ch);
    dig_ok = (base_in != BASE_AUTO) && (dval < base_in);
    prod   = PROD_W'(acc_in) * PROD_W'(base_in) + PROD_W'(dval);

    acc_t = acc_in;
    st_t  = st_in;
    if (dig_ok && st_in != DS_OVERFLOW) begin
      if (|prod[PROD_W-1:VALUE_W]) begin
        acc_t = '1;
        st_t  = DS_OVERFLOW;
      end else begin
        acc_t = prod[VALUE_W-1:0];
        st_t  = DS_DIGITS;
      end
    end
  end

  // Phase sequencing
  always_comb begin
    phase_nxt = phase_cur;
    acc_nxt   = acc_cur;
    neg_nxt   = neg_cur;
    st_nxt    = st_cur;
    base_nxt  = base_cur;
    emit      = 1'b0;

    unique case (phase_cur)
      PH_LEAD, PH_SIGNED: begin
        if (phase_cur == PH_LEAD && is_ws) begin
          phase_nxt = PH_LEAD;
        end else if (phase_cur == PH_LEAD && ch == CH_MINUS) begin
          neg_nxt   = 1'b1;
          phase_nxt = PH_SIGNED;
        end else if (phase_cur == PH_LEAD && ch == CH_PLUS) begin
          phase_nxt = PH_SIGNED;
        end else if (zero_lead) begin
          phase_nxt = PH_ZERO;
        end else begin
          base_nxt  = base_in;
          acc_nxt   = acc_t;
          st_nxt    = st_t;
          phase_nxt = dig_ok ? PH_DIGITS : PH_DONE;
          emit      = !dig_ok;
        end
      end
      PH_ZERO: begin
        if (ch == CH_LX || ch == CH_UX) begin
          base_nxt  = BASE_HEX;
          phase_nxt = PH_DIGITS;
        end else begin
          base_nxt  = base_in;
          acc_nxt   = acc_t;
          st_nxt    = st_t;
          phase_nxt = dig_ok ? PH_DIGITS : PH_DONE;
          emit      = !dig_ok;
        end
      end
      PH_DIGITS: begin
        acc_nxt   = acc_t;
        st_nxt    = st_t;
        phase_nxt = dig_ok ? PH_DIGITS : PH_DONE;
        emit      = !dig_ok;
      end
      PH_IDLE, PH_DONE: begin
        phase_nxt = phase_cur;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase

    // position advances while a parse is live, saturating
    pos_nxt = pos_cur;
    if (phase_nxt != PH_IDLE && phase_nxt != PH_DONE && pos_cur < POS_MAX) begin
      pos_nxt = pos_cur + POS_W'(1);
    end
  end

  // Result word
  always_comb begin
    pos_ext         = EXT_W'(pos_cur);
    res.value       = (neg_cur && st_t == DS_DIGITS) ? ('0 - acc_t) : acc_t;
    res.converted   = (st_t != DS_NONE);
    res.range_error = (st_t == DS_OVERFLOW);
    if (st_t == DS_NONE) begin
      res.end_offset = '0;
    end else if (pos_ext > OFS_MAX) begin
      res.end_offset = '1;
    end else begin
      res.end_offset = pos_ext[OFFSET_W-1:0];
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      st_r    <= DS_NONE;
      base_r  <= BASE_AUTO;
      pos_r   <= '0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      st_r    <= st_nxt;
      base_r  <= base_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_pop) begin
      // skid word moves up, or a fresh word takes the freed slot
      out_valid_r  <= skid_valid_r || (in_fire && emit);
      skid_valid_r <= 1'b0;
    end else if (in_fire && emit) begin
      if (!out_valid_r) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_pop && skid_valid_r) begin
      out_r <= skid_r;
    end else if (in_fire && emit && (!out_valid_r || out_pop)) begin
      out_r <= res;
    end
    if (in_fire && emit && out_valid_r && !out_pop) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.end_offset, out_r.value};
  assign out_tuser  = {out_r.range_error, out_r.converted};

endmodule

// ===== design/atou64_checker.sv =====
`include "assert_macros.svh"

module atou64_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [atou64_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [atou64_pkg::OUT_TUSER_W-1:0] out_tuser
);
  import atou64_pkg::*;

  // a stalled result word stays offered
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)

  // and does not change under stall
  `ASSERT_NEXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tuser))

  // overflow only on a converted number, and saturates to all ones
  `ASSERT_IMPL(a_range_conv, clk, rst_n, out_tvalid && out_tuser[1], out_tuser[0] && (&out_tdata[VALUE_W-1:0]))

  // nothing converted: zero value, zero offset
  `ASSERT_IMPL(a_noconv_zero, clk, rst_n, out_tvalid && !out_tuser[0], out_tdata == '0)

endmodule

bind ascii_to_unsigned64_parser atou64_checker u_atou64_checker (.*);

// ===== tb/sv/parse_result_checker.sv =====
// Watches the parser's three channels, keeps its own model of the parse and
// compares every result word against the oldest prediction.
module parse_result_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  input  logic                               in_tready,
  input  logic [atou64_pkg::CHAR_W-1:0]      in_tdata,   // [7:0] char_code
  input  logic [0:0]                         in_tuser,   // [0] start_of_string
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic [atou64_pkg::OUT_TDATA_W-1:0] out_tdata,  // [63:0] value, [79:64] end_offset
  input  logic [atou64_pkg::OUT_TUSER_W-1:0] out_tuser,  // [0] converted, [1] range_error
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [atou64_pkg::RADIX_W-1:0]     cfg_data,
  output int                                 error_count,
  output int                                 pending_count,
  output int                                 result_count,
  output int                                 saturated_count
);
  import atou64_pkg::*;

  localparam int unsigned NOT_A_DIGIT = 99;
  localparam int          MAX_REPORTS = 10;
  localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;

  // Model of the parse
  logic [RADIX_W-1:0]  radix_copy;
  logic [RADIX_W-1:0]  base;
  phase_t              ph;
  logic [VALUE_W-1:0]  acc;
  logic                neg;
  dstat_t              dstat;
  logic [OFFSET_W-1:0] pos;

  result_t expected_results[$];
  int errors;
  int checked;
  int saturated;

  function automatic int unsigned char_digit(input logic [CHAR_W-1:0] ch);
    if (ch >= CH_ZERO && ch <= CH_NINE) return 32'(ch - CH_ZERO);
    if (ch >= CH_UA && ch <= CH_UZ) return 32'(ch - CH_UA) + 32'(LETTER_OFS);
    if (ch >= CH_LA && ch <= CH_LZ) return 32'(ch - CH_LA) + 32'(LETTER_OFS);
    return NOT_A_DIGIT;
  endfunction

  // Multiply-add with a wide product; saturate once it no longer fits
  function automatic bit accept_digit(input logic [CHAR_W-1:0] ch);
    int unsigned d;
    logic [VALUE_W+6:0] wide;
    d = char_digit(ch);
    if (base == BASE_AUTO || d >= 32'(base)) return 1'b0;
    if (dstat == DS_OVERFLOW) return 1'b1;
    wide = (VALUE_W+7)'(acc) * (VALUE_W+7)'(base) + (VALUE_W+7)'(d);
    if (wide[VALUE_W+6:VALUE_W] != '0) begin
      acc = '1;
      dstat = DS_OVERFLOW;
    end else begin
      acc = wide[VALUE_W-1:0];
      dstat = DS_DIGITS;
    end
    return 1'b1;
  endfunction

  function automatic void emit_result();
    result_t r;
    r.value       = (neg && dstat == DS_DIGITS) ? VALUE_W'(0) - acc : acc;
    r.end_offset  = (dstat != DS_NONE) ? pos : '0;
    r.converted   = (dstat != DS_NONE);
    r.range_error = (dstat == DS_OVERFLOW);
    expected_results.push_back(r);
    ph = PH_DONE;
  endfunction

  // First character after whitespace and sign
  function automatic void first_char(input logic [CHAR_W-1:0] ch);
    if ((base == BASE_AUTO || base == BASE_HEX) && ch == CH_ZERO) begin
      ph = PH_ZERO;
    end else begin
      if (base == BASE_AUTO) base = BASE_DEC;
      ph = PH_DIGITS;
      if (!accept_digit(ch)) emit_result();
    end
  endfunction

  function automatic void predict_char(input logic [CHAR_W-1:0] ch, input logic sos);
    if (sos) begin
      ph    = PH_LEAD;
      acc   = '0;
      neg   = 1'b0;
      dstat = DS_NONE;
      base  = radix_copy;
      pos   = '0;
    end
    case (ph)
      PH_LEAD: begin
        if ((ch >= CH_TAB && ch <= CH_CR) || ch == CH_SPACE) begin
          // leading whitespace is skipped
        end else if (ch == CH_MINUS) begin
          neg = 1'b1;
          ph = PH_SIGNED;
        end else if (ch == CH_PLUS) begin
          ph = PH_SIGNED;
        end else begin
          first_char(ch);
        end
      end
      PH_SIGNED: first_char(ch);
      PH_ZERO: begin
        if (ch == CH_LX || ch == CH_UX) begin
          base = BASE_HEX;
          ph = PH_DIGITS;
        end else begin
          if (base == BASE_AUTO) base = BASE_OCT;
          ph = PH_DIGITS;
          void'(accept_digit(CH_ZERO));
          if (!accept_digit(ch)) emit_result();
        end
      end
      PH_DIGITS: if (!accept_digit(ch)) emit_result();
      default: ;
    endcase
    if (ph != PH_IDLE && ph != PH_DONE && pos != OFFSET_MAX) pos = pos + 1'b1;
  endfunction

  function automatic void check_result();
    result_t want;
    logic [VALUE_W-1:0]  got_value;
    logic [OFFSET_W-1:0] got_offset;
    logic                got_conv;
    logic                got_range;
    got_value  = out_tdata[VALUE_W-1:0];
    got_offset = out_tdata[VALUE_W +: OFFSET_W];
    got_conv   = out_tuser[0];
    got_range  = out_tuser[1];
    if (expected_results.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("unexpected result word: value %h offset %0d conv %0b range %0b",
                 got_value, got_offset, got_conv, got_range);
    end else begin
      want = expected_results.pop_front();
      checked++;
      if (want.range_error) saturated++;
      if (got_value !== want.value || got_offset !== want.end_offset ||
          got_conv !== want.converted || got_range !== want.range_error) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("result mismatch: expected value %h offset %0d conv %0b range %0b",
                   want.value, want.end_offset, want.converted, want.range_error);
          $display("                 got      value %h offset %0d conv %0b range %0b",
                   got_value, got_offset, got_conv, got_range);
        end
      end
    end
  endfunction

  // Results are checked before the same edge's character is modeled:
  // a result always belongs to an earlier character.
  always @(posedge clk) begin
    if (!rst_n) begin
      radix_copy = BASE_AUTO;
      ph         = PH_IDLE;
      acc        = '0;
      neg        = 1'b0;
      dstat      = DS_NONE;
      base       = BASE_AUTO;
      pos        = '0;
      errors     = 0;
      checked    = 0;
      saturated  = 0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) radix_copy = cfg_data;
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready) predict_char(in_tdata, in_tuser[0]);
    end
    error_count     <= errors;
    pending_count   <= expected_results.size();
    result_count    <= checked;
    saturated_count <= saturated;
  end

endmodule

// ===== tb/sv/ascii_to_unsigned64_parser_test.sv =====
// Stimulus and verdict for the string-to-number parser; checking lives in
// parse_result_checker.
module ascii_to_unsigned64_parser_test;
  import atou64_pkg::*;

  localparam int CYCLE_LIMIT = 500_000;
  localparam int PHASE_ITEMS = 130;
  localparam int LONG_RUN    = 100;
  localparam int unsigned DIGIT_SPAN = 36;
  localparam logic [CHAR_W-1:0]  CH_NUL   = 8'h00;
  localparam logic [VALUE_W-1:0] ALL_ONES = '1;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [CHAR_W-1:0]      in_tdata   = '0;   // [7:0] char_code
  logic [0:0]             in_tuser   = '0;   // [0] start_of_string
  logic                   out_tvalid;
  logic                   out_tready = 1'b1;
  logic [OUT_TDATA_W-1:0] out_tdata;         // [63:0] value, [79:64] end_offset
  logic [OUT_TUSER_W-1:0] out_tuser;         // [0] converted, [1] range_error
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [RADIX_W-1:0]     cfg_data   = '0;

  int error_count;
  int pending_count;
  int result_count;
  int saturated_count;

  bit idle_on      = 1'b1;
  int stall_left   = 0;
  int string_count = 0;
  int setting_count = 0;

  logic [CHAR_W-1:0]  text_q[$];
  logic [RADIX_W-1:0] radix_plan[$];

  ascii_to_unsigned64_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  parse_result_checker result_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .error_count     (error_count),
    .pending_count   (pending_count),
    .result_count    (result_count),
    .saturated_count (saturated_count)
  );

  always #5 clk = ~clk;

  // Run limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("run limit reached with %0d results outstanding", pending_count);
    $display("** ascii_to_unsigned64_parser: FAILED **");
    $finish;
  end

  // Receiver: random stall bursts while idling is on
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 10) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // One character word, with an optional idle burst ahead of it
  task automatic send_word(input logic [CHAR_W-1:0] ch, input logic sos);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid   <= 1'b1;
    in_tdata    <= ch;
    in_tuser[0] <= sos;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_word(text_q[i], i == 0);
    string_count++;
  endtask

  // Stop sending until every result is back, then let the pipe settle
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_radix(input logic [RADIX_W-1:0] r);
    cfg_valid <= 1'b1;
    cfg_data  <= r;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    setting_count++;
  endtask

  function automatic logic [CHAR_W-1:0] digit_char(input int unsigned v);
    if (v < 32'(LETTER_OFS)) return CH_ZERO + CHAR_W'(v);
    return ($urandom_range(0, 1) ? CH_UA : CH_LA) + CHAR_W'(v) - CHAR_W'(LETTER_OFS);
  endfunction

  // Builds one string: mostly well-formed numbers in the active base,
  // with boundary values, long overflowing runs and some raw noise.
  task automatic make_number_text(input logic [RADIX_W-1:0] rad);
    int unsigned eff;
    int unsigned span;
    int unsigned n;
    int unsigned v;
    int unsigned mode;
    logic [VALUE_W-1:0] q;
    logic [CHAR_W-1:0]  digits[$];
    text_q.delete();
    eff = rad;
    if ($urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 8);
      repeat (n) text_q.push_back(CHAR_W'($urandom_range(0, 255)));
    end else begin
      // leading whitespace
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 5) == 0) text_q.push_back(CH_SPACE);
          else text_q.push_back(CH_TAB + CHAR_W'($urandom_range(0, 4)));
        end
      end
      case ($urandom_range(0, 3))
        0: text_q.push_back(CH_MINUS);
        1: text_q.push_back(CH_PLUS);
        default: ;
      endcase
      // hex or octal prefix where the base allows one
      if (rad == BASE_AUTO || rad == BASE_HEX) begin
        case ($urandom_range(0, 3))
          0: begin
            text_q.push_back(CH_ZERO);
            text_q.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
            eff = BASE_HEX;
          end
          1: if (rad == BASE_AUTO) begin
            text_q.push_back(CH_ZERO);
            eff = BASE_OCT;
          end
          default: ;
        endcase
      end
      if (eff == 0) eff = BASE_DEC;
      span = (eff > DIGIT_SPAN) ? DIGIT_SPAN : eff;
      mode = $urandom_range(0, 15);
      if (mode == 0 && eff >= 2 && eff <= DIGIT_SPAN) begin
        // digits right at the saturation boundary
        q = ALL_ONES / eff - VALUE_W'($urandom_range(0, 1));
        while (q != 0) begin
          digits.push_front(digit_char(32'(q % eff)));
          q = q / eff;
        end
        foreach (digits[i]) text_q.push_back(digits[i]);
        repeat ($urandom_range(1, 3)) text_q.push_back(digit_char($urandom_range(0, eff - 1)));
      end else begin
        n = (mode == 1) ? $urandom_range(20, 70) : $urandom_range(0, 12);
        for (int i = 0; i < n; i++) begin
          v = $urandom_range(0, span - 1);
          // keep an unprefixed auto-base number decimal
          if (i == 0 && rad == BASE_AUTO && eff == BASE_DEC && v == 0) v = 1;
          text_q.push_back(digit_char(v));
        end
      end
      // terminator: NUL, any byte, or none (next start drops the parse)
      n = $urandom_range(0, 9);
      if (n < 4) text_q.push_back(CH_NUL);
      else if (n < 9) text_q.push_back(CHAR_W'($urandom_range(0, 255)));
      // junk after the result is ignored
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) text_q.push_back(CHAR_W'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int phase_items;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_radix(BASE_AUTO);

    // Directed: characters before any start are ignored
    send_word(CH_ZERO + 8'd5, 1'b0);
    send_word(CH_LA, 1'b0);
    // whitespace, minus and hex prefix: negated value
    text_q = '{CH_SPACE, CH_TAB, CH_MINUS, CH_ZERO, CH_LX, CH_ZERO + 8'd1, CH_UA + 8'd5,
               CH_NUL};
    send_text();
    // prefix with no digit behind it
    text_q = '{CH_ZERO, CH_UX, CH_LA + 8'd6};
    send_text();
    // leading zero selects octal; an octal-invalid digit ends it
    text_q = '{CH_PLUS, CH_ZERO, CH_ZERO + 8'd1, CH_ZERO + 8'd7, CH_ZERO + 8'd9};
    send_text();
    // whitespace after the sign is not skipped
    text_q = '{CH_MINUS, CH_SPACE};
    send_text();
    // new start drops the unfinished parse
    text_q = '{CH_ZERO + 8'd1, CH_ZERO + 8'd2};
    send_text();
    text_q = '{CH_ZERO + 8'd3, CH_NUL};
    send_text();
    // ignored after the result
    send_word(CH_ZERO + 8'd7, 1'b0);

    // Random strings across a range of bases, extremes included
    radix_plan = '{BASE_DEC, BASE_HEX, BASE_AUTO, BASE_OCT, 6'd2, 6'd1, 6'd36, 6'd37,
                   6'd63, RADIX_W'($urandom_range(0, 63)), RADIX_W'($urandom_range(0, 63)),
                   BASE_DEC};
    foreach (radix_plan[p]) begin
      drain();
      write_radix(radix_plan[p]);
      idle_on = (p != radix_plan.size() - 1);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        make_number_text(radix_plan[p]);
        send_text();
        phase_items += text_q.size();
      end
    end

    // One long string of leading zeros ahead of a single digit
    send_word(CH_ZERO, 1'b1);
    repeat (LONG_RUN) send_word(CH_ZERO, 1'b0);
    send_word(CH_ZERO + 8'd7, 1'b0);
    send_word(CH_NUL, 1'b0);
    string_count++;

    drain();
    repeat (10) @(posedge clk);
    $display("%0d strings over %0d radix settings, one of %0d characters",
             string_count, setting_count, LONG_RUN + 3);
    $display("%0d results checked, %0d of them saturated", result_count, saturated_count);
    if (error_count == 0 && pending_count == 0) begin
      $display("** ascii_to_unsigned64_parser: PASSED **");
    end else begin
      $display("** ascii_to_unsigned64_parser: FAILED **");
    end
    $finish;
  end

endmodule
